FILE: rtl/extended_precision_scale_core_assert.svh
// assertion macros for the extended precision scale core
`ifndef EXTENDED_PRECISION_SCALE_CORE_ASSERT_SVH
`define EXTENDED_PRECISION_SCALE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define EPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define EPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define EPS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define EPS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/eps_pkg.sv
// shared types and constants for the extended precision scale core
`timescale 1ns / 1ps
package eps_pkg;
  localparam logic [63:0] SIG_TOP = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SIG_QUIET = 64'hc000_0000_0000_0000;
  localparam logic [14:0] EXP_BIAS = 15'h3fff;
  localparam logic [14:0] EXP_MAX_FINITE = 15'h7ffe;
  localparam logic [14:0] EXP_SPECIAL = 15'h7fff;
  localparam logic [18:0] SCALE_CLAMP = 19'd131072;
  localparam logic [19:0] WRAP_BIAS = 20'd24576;

  localparam logic [1:0] RC_NEAREST = 2'd0;
  localparam logic [1:0] RC_DOWN = 2'd1;
  localparam logic [1:0] RC_UP = 2'd2;

  localparam int FL_INVALID = 0;
  localparam int FL_DENORMAL = 1;
  localparam int FL_ZERO_DIVIDE = 2;
  localparam int FL_OVERFLOW = 3;
  localparam int FL_UNDERFLOW = 4;
  localparam int FL_PRECISION = 5;

  // decoded item after the first stage
  typedef struct packed {
    logic        done;
    logic [63:0] sig;
    logic [15:0] se;
    logic [5:0]  flags;
    logic        sign;
    logic        sneg;
    logic [63:0] sb;
    logic [14:0] bx;
    logic [15:0] cw;
  } dec_t;

  // item with normalized significand and scale amount
  typedef struct packed {
    logic        done;
    logic [63:0] sig;
    logic [15:0] se;
    logic [5:0]  flags;
    logic        sign;
    logic signed [19:0] exponent;
    logic [15:0] cw;
  } norm_t;

  typedef struct packed {
    logic [63:0] sig;
    logic [15:0] se;
    logic [5:0]  flags;
    logic        up;
  } res_t;

  function automatic logic [6:0] lzc64(input logic [63:0] v);
    logic [6:0] n;
    logic       hit;
    n = 7'd64;
    hit = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n = 7'(63 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction
endpackage

FILE: rtl/extended_precision_scale_core.sv
// top level of the extended precision scale core
// Usage:
// An item is taken on a rising edge with start high and busy low. busy is
// always low: the core is a three-stage pipeline and accepts one item every
// cycle. The result fields are registered by stage one, stage two and stage
// three in turn, and done is high for exactly one cycle when they appear; the
// receiver cannot stall and must take it then. Stage one decodes operands
// and special cases, stage two extracts the scale and normalizes a denormal
// with a leading-zero count, stage three applies overflow, underflow and
// rounding.
// control_word is written with cfg_we and cfg_wdata and must only change
// while no item is in flight. Reset (rst, synchronous) empties the pipeline
// and sets control_word to 0x037f.
// Throughput: one item per cycle.
`timescale 1ns / 1ps
`include "extended_precision_scale_core_assert.svh"
module extended_precision_scale_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic [63:0] dest_significand,
  input  logic [15:0] dest_sign_exponent,
  input  logic [63:0] scale_significand,
  input  logic [15:0] scale_sign_exponent,
  output logic        done,
  output logic [63:0] result_significand,
  output logic [15:0] result_sign_exponent,
  output logic [5:0]  status_flags,
  output logic        round_away
);
  import eps_pkg::*;

  logic [15:0] control_word;
  logic v1, v2;
  dec_t d1;
  norm_t n2;
  res_t r3;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_word <= 16'h037f;
    end else if (cfg_we) begin
      control_word <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  eps_decode u_dec (.clk, .rst, .in_valid(start), .sa(dest_significand),
    .ea(dest_sign_exponent), .sb(scale_significand), .eb(scale_sign_exponent),
    .cw(control_word), .out_valid(v1), .out_item(d1));
  eps_normalize u_norm (.clk, .rst, .in_valid(v1), .in_item(d1),
    .out_valid(v2), .out_item(n2));
  eps_round u_rnd (.clk, .rst, .in_valid(v2), .in_item(n2),
    .out_valid(done), .out_item(r3));

  assign result_significand = r3.sig;
  assign result_sign_exponent = r3.se;
  assign status_flags = r3.flags;
  assign round_away = r3.up;

  `EPS_ASSERT_NEXT(a_s1, clk, rst, start, v1)
  `EPS_ASSERT_NEXT(a_s2, clk, rst, v1, v2)
  `EPS_ASSERT_NEXT(a_s3, clk, rst, v2, done)
  `EPS_ASSERT_IMPL(a_zd, clk, rst, done, !status_flags[FL_ZERO_DIVIDE])
endmodule

FILE: rtl/eps_decode.sv
// stage one: operand classification and special cases
`timescale 1ns / 1ps
module eps_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [63:0]     sa,
  input  logic [15:0]     ea,
  input  logic [63:0]     sb,
  input  logic [15:0]     eb,
  input  logic [15:0]     cw,
  output logic            out_valid,
  output eps_pkg::dec_t   out_item
);
  import eps_pkg::*;

  dec_t d_next;

  always_comb begin
    logic [15:0] ca, cb;
    logic [14:0] ax, bx;
    logic sna, snb, na, nb, take_a, az, ai, bi, sneg, den;
    d_next = '0;
    d_next.cw = cw;
    d_next.sign = ea[15];
    d_next.sb = sb;
    ca = ea;
    cb = eb;
    if (ea[14:0] == '0 && sa[63]) ca = ea | 16'd1;
    if (eb[14:0] == '0 && sb[63]) cb = eb | 16'd1;
    ax = ca[14:0];
    bx = cb[14:0];
    d_next.bx = bx;
    sneg = eb[15];
    d_next.sneg = sneg;
    na = ax == EXP_SPECIAL && sa[62:0] != '0;
    nb = bx == EXP_SPECIAL && sb[62:0] != '0;
    sna = ax == EXP_SPECIAL && !sa[62] && sa[61:0] != '0;
    snb = bx == EXP_SPECIAL && !sb[62] && sb[61:0] != '0;
    if (ax != bx) take_a = ax > bx;
    else if (sa != sb) take_a = sa > sb;
    else take_a = ca < cb;
    if (sna && !snb) take_a = !nb;
    else if (!sna && snb) take_a = na;
    az = sa == '0;
    ai = ax == EXP_SPECIAL;
    bi = bx == EXP_SPECIAL;
    den = (ea[14:0] == '0 && sa != '0) || (eb[14:0] == '0 && sb != '0);
    d_next.sig = sa;
    d_next.se = ca;
    if ((ea[14:0] != '0 && !sa[63]) || (eb[14:0] != '0 && !sb[63])) begin
      d_next.done = 1'b1;
      d_next.sig = SIG_QUIET;
      d_next.se = 16'hffff;
      d_next.flags[FL_INVALID] = 1'b1;
    end else if ((ai && sa != SIG_TOP) || (bi && sb != SIG_TOP)) begin
      d_next.done = 1'b1;
      d_next.flags[FL_INVALID] = sna || snb;
      d_next.sig = (take_a ? sa : sb) | SIG_QUIET;
      d_next.se = take_a ? ca : cb;
    end else if (bi && ((az && !sneg) || (ai && sneg))) begin
      d_next.done = 1'b1;
      d_next.sig = SIG_QUIET;
      d_next.se = 16'hffff;
      d_next.flags[FL_INVALID] = 1'b1;
    end else begin
      d_next.flags[FL_DENORMAL] = den;
      if (den && !cw[1]) begin
        d_next.done = 1'b1;
      end else if (bi) begin
        d_next.done = 1'b1;
        d_next.sig = sneg ? 64'd0 : SIG_TOP;
        d_next.se = {ea[15], sneg ? 15'd0 : EXP_SPECIAL};
      end else if (az || ai || sb == '0) begin
        d_next.done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_item <= d_next;
  end
endmodule

FILE: rtl/eps_normalize.sv
// stage two: scale extraction and significand normalization
`timescale 1ns / 1ps
module eps_normalize (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  eps_pkg::dec_t   in_item,
  output logic            out_valid,
  output eps_pkg::norm_t  out_item
);
  import eps_pkg::*;

  norm_t n_next;

  always_comb begin
    logic signed [16:0] k;
    logic [18:0] scale;
    logic [6:0] lz;
    logic signed [19:0] ex;
    n_next = '0;
    n_next.done = in_item.done;
    n_next.se = in_item.se;
    n_next.flags = in_item.flags;
    n_next.sign = in_item.sign;
    n_next.cw = in_item.cw;
    k = 17'($signed({2'b0, in_item.bx})) - 17'($signed({2'b0, EXP_BIAS}));
    scale = '0;
    if (k >= 17) scale = SCALE_CLAMP;
    else if (k >= 0) scale = 19'(in_item.sb >> (7'd63 - 7'(k)));
    ex = 20'($signed({5'b0, in_item.se[14:0]}));
    lz = lzc64(in_item.sig);
    n_next.sig = in_item.sig;
    // true denormal: normalize with exponent going below one
    if (in_item.se[14:0] == '0 && !in_item.done) begin
      n_next.sig = in_item.sig << lz[5:0];
      ex = 20'sd1 - 20'($signed({13'b0, lz}));
    end
    n_next.exponent = in_item.sneg ? ex - 20'($signed({1'b0, scale}))
                                   : ex + 20'($signed({1'b0, scale}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_item <= n_next;
  end
endmodule

FILE: rtl/eps_round.sv
// stage three: overflow, underflow and rounding
`timescale 1ns / 1ps
module eps_round (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  eps_pkg::norm_t  in_item,
  output logic            out_valid,
  output eps_pkg::res_t   out_item
);
  import eps_pkg::*;

  res_t r_next;

  always_comb begin
    logic signed [19:0] ex, wr;
    logic [1:0] rc;
    logic outward, inf, inc;
    logic [19:0] shift;
    logic [63:0] trunc, tail, half, mask;
    r_next.sig = in_item.sig;
    r_next.se = in_item.se;
    r_next.flags = in_item.flags;
    r_next.up = 1'b0;
    ex = in_item.exponent;
    wr = '0;
    inf = 1'b0;
    inc = 1'b0;
    rc = in_item.cw[11:10];
    outward = rc == (in_item.sign ? RC_DOWN : RC_UP);
    shift = 20'(20'sd1 - ex);
    trunc = '0;
    tail = in_item.sig;
    half = '0;
    mask = '0;
    if (shift < 20'd64) begin
      mask = (64'd1 << shift[5:0]) - 64'd1;
      trunc = in_item.sig >> shift[5:0];
      tail = in_item.sig & mask;
      half = 64'd1 << (shift[5:0] - 6'd1);
    end else if (shift == 20'd64) begin
      half = SIG_TOP;
    end
    if (!in_item.done) begin
      r_next.se = {in_item.sign, ex[14:0]};
      if (ex > 20'($signed({5'b0, EXP_MAX_FINITE}))) begin
        r_next.flags[FL_OVERFLOW] = 1'b1;
        wr = ex - 20'($signed(WRAP_BIAS));
        if (!in_item.cw[3] && wr <= 20'($signed({5'b0, EXP_MAX_FINITE}))) begin
          r_next.se = {in_item.sign, wr[14:0]};
        end else begin
          inf = !in_item.cw[3] || rc == RC_NEAREST || outward;
          r_next.sig = inf ? SIG_TOP : '1;
          r_next.se = {in_item.sign, inf ? EXP_SPECIAL : EXP_MAX_FINITE};
          r_next.flags[FL_PRECISION] = 1'b1;
          r_next.up = inf;
        end
      end else if (ex <= 20'sd0) begin
        if (!in_item.cw[4]) begin
          wr = ex + 20'($signed(WRAP_BIAS));
          r_next.flags[FL_UNDERFLOW] = 1'b1;
          if (wr > 20'sd0) begin
            r_next.se = {in_item.sign, wr[14:0]};
          end else begin
            r_next.sig = '0;
            r_next.se = {in_item.sign, 15'd0};
            r_next.flags[FL_PRECISION] = 1'b1;
          end
        end else begin
          inc = tail != '0 && (rc == RC_NEAREST ?
                (shift <= 20'd64 && (tail > half || (tail == half && trunc[0])))
                : outward);
          r_next.sig = trunc + {63'd0, inc};
          r_next.se = {in_item.sign, 14'd0, r_next.sig[63]};
          r_next.up = inc;
          if (tail != '0) begin
            r_next.flags[FL_UNDERFLOW] = 1'b1;
            r_next.flags[FL_PRECISION] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_item <= r_next;
  end
endmodule
